FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define EA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define EA_ASSERT_IMPL(lbl, ante, cons, msg) \
    `EA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: design/ea2rm_pkg.sv
// ---------------------------------------------------------------------------
// ea2rm_pkg
// Widths, payload types and arithmetic helpers for the rotation matrix block.
// ---------------------------------------------------------------------------
package ea2rm_pkg;

    localparam int ANG_W = 17;
    localparam int OUT_W = 16;
    localparam int REM_W = 14;
    localparam int XW = 34;
    localparam int ZW = 26;
    localparam int TW = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [ANG_W:0] FULL_TURN = 18'sd46080;
    localparam logic signed [ANG_W:0] QUARTER_TURN = 18'sd11520;
    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [TW-1:0] ONE_Q30 = 32'sd1073741824;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Lane 0 is roll, lane 1 is pitch, lane 2 is yaw.
    typedef struct packed {
        logic [2:0]            zero;
        logic [2:0][1:0]       quad;
        logic [2:0][REM_W-1:0] rem;
    } red_t;

    typedef struct packed {
        logic [2:0][TW-1:0] sn;
        logic [2:0][TW-1:0] cs;
    } trig_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] row0_col0;
        logic signed [OUT_W-1:0] row1_col0;
        logic signed [OUT_W-1:0] row2_col0;
        logic signed [OUT_W-1:0] row0_col1;
        logic signed [OUT_W-1:0] row1_col1;
        logic signed [OUT_W-1:0] row2_col1;
        logic signed [OUT_W-1:0] row0_col2;
        logic signed [OUT_W-1:0] row1_col2;
        logic signed [OUT_W-1:0] row2_col2;
    } mat_t;

    // atan(2^-i) in degrees times 65536.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    // Q1.30 product with round half up.
    function automatic logic signed [TW-1:0] qmul(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] ae;
        logic signed [2*TW-1:0] be;
        logic signed [2*TW-1:0] p;
        ae = a;
        be = b;
        p = ae * be + 64'sd536870912;
        return p[61:30];
    endfunction

    function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [TW:0] v);
        logic signed [TW+1:0] t;
        t = ($signed({v[TW], v}) + 34'sd16384) >>> 15;
        if (t > 34'sd32767)
            return 16'sh7fff;
        if (t < -34'sd32768)
            return 16'sh8000;
        return t[OUT_W-1:0];
    endfunction

endpackage

FILE: design/ea2rm_angle_if.sv
// ---------------------------------------------------------------------------
// ea2rm_angle_if
// Request channel carrying one roll, pitch and yaw triple.
// ---------------------------------------------------------------------------
interface ea2rm_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ea2rm_pkg::ANG_W-1:0]   roll_angle;
    logic signed [ea2rm_pkg::ANG_W-1:0]   pitch_angle;
    logic signed [ea2rm_pkg::ANG_W-1:0]   yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, input ready);
    modport sink (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

FILE: design/ea2rm_matrix_if.sv
// ---------------------------------------------------------------------------
// ea2rm_matrix_if
// Request channel carrying the nine Q1.15 rotation matrix entries.
// ---------------------------------------------------------------------------
interface ea2rm_matrix_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row0_col0;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row1_col0;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row2_col0;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row0_col1;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row1_col1;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row2_col1;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row0_col2;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row1_col2;
    logic signed [ea2rm_pkg::OUT_W-1:0]   row2_col2;

    modport source (output valid, output row0_col0, output row1_col0, output row2_col0,
                    output row0_col1, output row1_col1, output row2_col1,
                    output row0_col2, output row1_col2, output row2_col2, input ready);
    modport sink (input valid, input row0_col0, input row1_col0, input row2_col0,
                  input row0_col1, input row1_col1, input row2_col1,
                  input row0_col2, input row1_col2, input row2_col2, output ready);
endinterface

FILE: design/ea2rm_reduce.sv
// ---------------------------------------------------------------------------
// ea2rm_reduce
// Wraps each angle into one turn and splits it into quadrant and remainder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ea2rm_reduce (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0][ea2rm_pkg::ANG_W-1:0]  in_angle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ea2rm_pkg::red_t                   out_data
);

    logic            valid_reg;
    logic            advance;
    ea2rm_pkg::red_t data_reg;
    ea2rm_pkg::red_t data_next;

    assign advance = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        logic signed [ea2rm_pkg::ANG_W:0] a;
        logic signed [ea2rm_pkg::ANG_W:0] w;
        logic signed [ea2rm_pkg::ANG_W:0] r;
        data_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            a = $signed({in_angle[k][ea2rm_pkg::ANG_W-1], in_angle[k]});
            if (a < -ea2rm_pkg::FULL_TURN)
                w = a + ea2rm_pkg::FULL_TURN + ea2rm_pkg::FULL_TURN;
            else if (a < 0)
                w = a + ea2rm_pkg::FULL_TURN;
            else if (a >= ea2rm_pkg::FULL_TURN)
                w = a - ea2rm_pkg::FULL_TURN;
            else
                w = a;
            if (w < ea2rm_pkg::QUARTER_TURN)
            begin
                data_next.quad[k] = ea2rm_pkg::QUAD_0;
                r = w;
            end
            else if (w < 2 * ea2rm_pkg::QUARTER_TURN)
            begin
                data_next.quad[k] = ea2rm_pkg::QUAD_1;
                r = w - ea2rm_pkg::QUARTER_TURN;
            end
            else if (w < 3 * ea2rm_pkg::QUARTER_TURN)
            begin
                data_next.quad[k] = ea2rm_pkg::QUAD_2;
                r = (ea2rm_pkg::ANG_W+1)'(w - 2 * ea2rm_pkg::QUARTER_TURN);
            end
            else
            begin
                data_next.quad[k] = ea2rm_pkg::QUAD_3;
                r = (ea2rm_pkg::ANG_W+1)'(w - 3 * ea2rm_pkg::QUARTER_TURN);
            end
            data_next.rem[k] = r[ea2rm_pkg::REM_W-1:0];
            data_next.zero[k] = (r == 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

    `EA_ASSERT_IMPL(a_rem_in_quadrant, valid_reg,
        (data_reg.rem[0] < 14'd11520) && (data_reg.rem[1] < 14'd11520)
        && (data_reg.rem[2] < 14'd11520), "remainder outside one quadrant")
    `EA_ASSERT_IMPL(a_zero_flag, valid_reg,
        data_reg.zero[0] == (data_reg.rem[0] == '0), "zero flag disagrees with remainder")

endmodule

FILE: design/ea2rm_cordic.sv
// ---------------------------------------------------------------------------
// ea2rm_cordic
// Rotation-mode CORDIC, one step per pipeline stage, three lanes in lockstep,
// followed by a clamp and quadrant mapping stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ea2rm_cordic #(
    parameter int CORDIC_STEPS = ea2rm_pkg::CORDIC_STEPS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ea2rm_pkg::red_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ea2rm_pkg::trig_t out_data
);

    localparam int N = (CORDIC_STEPS > ea2rm_pkg::ATAN_ENTRIES) ?
                       ea2rm_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int XW = ea2rm_pkg::XW;
    localparam int ZW = ea2rm_pkg::ZW;
    localparam int TW = ea2rm_pkg::TW;

    logic                    valid_reg [N];
    logic signed [XW-1:0]    x_reg [N][3];
    logic signed [XW-1:0]    y_reg [N][3];
    logic signed [ZW-1:0]    z_reg [N][3];
    logic [2:0][1:0]         quad_reg [N];
    logic [2:0]              zero_reg [N];
    logic                    stage_ready [N+1];

    assign in_ready = stage_ready[0];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic                 v_in;
        logic signed [XW-1:0] x_in [3];
        logic signed [XW-1:0] y_in [3];
        logic signed [ZW-1:0] z_in [3];
        logic [2:0][1:0]      q_in;
        logic [2:0]           zr_in;
        logic                 advance;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                v_in = in_valid;
                q_in = in_data.quad;
                zr_in = in_data.zero;
                for (int l = 0; l < 3; l++)
                begin
                    x_in[l] = ea2rm_pkg::GAIN_Q30;
                    y_in[l] = '0;
                    z_in[l] = $signed({{(ZW-ea2rm_pkg::REM_W-9){1'b0}},
                                       in_data.rem[l], 9'b0});
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_in = valid_reg[k-1];
                q_in = quad_reg[k-1];
                zr_in = zero_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    x_in[l] = x_reg[k-1][l];
                    y_in[l] = y_reg[k-1][l];
                    z_in[l] = z_reg[k-1][l];
                end
            end
        end

        assign advance = !valid_reg[k] || stage_ready[k+1];
        assign stage_ready[k] = advance;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (advance)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance && v_in)
            begin
                quad_reg[k] <= q_in;
                zero_reg[k] <= zr_in;
                for (int l = 0; l < 3; l++)
                begin
                    if (z_in[l] >= 0)
                    begin
                        x_reg[k][l] <= x_in[l] - (y_in[l] >>> k);
                        y_reg[k][l] <= y_in[l] + (x_in[l] >>> k);
                        z_reg[k][l] <= z_in[l] - ea2rm_pkg::atan_lut(5'(k));
                    end
                    else
                    begin
                        x_reg[k][l] <= x_in[l] + (y_in[l] >>> k);
                        y_reg[k][l] <= y_in[l] - (x_in[l] >>> k);
                        z_reg[k][l] <= z_in[l] + ea2rm_pkg::atan_lut(5'(k));
                    end
                end
            end
        end
    end

    // Clamp to [0, 1.0] and map the first-quadrant pair onto the quadrant.
    logic             map_valid_reg;
    logic             map_advance;
    ea2rm_pkg::trig_t map_reg;
    ea2rm_pkg::trig_t map_next;

    assign map_advance = !map_valid_reg || out_ready;
    assign stage_ready[N] = map_advance;

    always_comb
    begin
        logic signed [TW-1:0] s0;
        logic signed [TW-1:0] c0;
        logic signed [XW-1:0] one_x;
        one_x = XW'(ea2rm_pkg::ONE_Q30);
        map_next = '0;
        for (int l = 0; l < 3; l++)
        begin
            if (y_reg[N-1][l] < 0)
                s0 = '0;
            else if (y_reg[N-1][l] > one_x)
                s0 = ea2rm_pkg::ONE_Q30;
            else
                s0 = y_reg[N-1][l][TW-1:0];
            if (x_reg[N-1][l] < 0)
                c0 = '0;
            else if (x_reg[N-1][l] > one_x)
                c0 = ea2rm_pkg::ONE_Q30;
            else
                c0 = x_reg[N-1][l][TW-1:0];
            if (zero_reg[N-1][l])
            begin
                s0 = '0;
                c0 = ea2rm_pkg::ONE_Q30;
            end
            case (ea2rm_pkg::quad_t'(quad_reg[N-1][l]))
                ea2rm_pkg::QUAD_0:
                begin
                    map_next.sn[l] = s0;
                    map_next.cs[l] = c0;
                end
                ea2rm_pkg::QUAD_1:
                begin
                    map_next.sn[l] = c0;
                    map_next.cs[l] = -s0;
                end
                ea2rm_pkg::QUAD_2:
                begin
                    map_next.sn[l] = -s0;
                    map_next.cs[l] = -c0;
                end
                default:
                begin
                    map_next.sn[l] = -c0;
                    map_next.cs[l] = s0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            map_valid_reg <= 1'b0;
        else if (map_advance)
            map_valid_reg <= valid_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (map_advance && valid_reg[N-1])
            map_reg <= map_next;
    end

    assign out_valid = map_valid_reg;
    assign out_data = map_reg;

    `EA_ASSERT_IMPL(a_sin_bounded, map_valid_reg,
        ($signed(map_reg.sn[0]) <= ea2rm_pkg::ONE_Q30)
        && ($signed(map_reg.sn[0]) >= -ea2rm_pkg::ONE_Q30), "roll sine beyond unit range")
    `EA_ASSERT_IMPL(a_cos_bounded, map_valid_reg,
        ($signed(map_reg.cs[2]) <= ea2rm_pkg::ONE_Q30)
        && ($signed(map_reg.cs[2]) >= -ea2rm_pkg::ONE_Q30), "yaw cosine beyond unit range")

endmodule

FILE: design/ea2rm_product.sv
// ---------------------------------------------------------------------------
// ea2rm_product
// Three stages: pair products, triple products, then sums and Q1.15 output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ea2rm_product (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ea2rm_pkg::trig_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ea2rm_pkg::mat_t  out_data
);

    localparam int TW = ea2rm_pkg::TW;

    typedef struct packed {
        logic signed [TW-1:0] srsp;
        logic signed [TW-1:0] crsp;
        logic signed [TW-1:0] cpcy;
        logic signed [TW-1:0] cpsy;
        logic signed [TW-1:0] srcp;
        logic signed [TW-1:0] crcp;
        logic signed [TW-1:0] crsy;
        logic signed [TW-1:0] crcy;
        logic signed [TW-1:0] srsy;
        logic signed [TW-1:0] srcy;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
        logic signed [TW-1:0] sp;
    } pair_t;

    typedef struct packed {
        logic signed [TW-1:0] srspcy;
        logic signed [TW-1:0] srspsy;
        logic signed [TW-1:0] crspcy;
        logic signed [TW-1:0] crspsy;
        logic signed [TW-1:0] cpcy;
        logic signed [TW-1:0] cpsy;
        logic signed [TW-1:0] sp;
        logic signed [TW-1:0] srcp;
        logic signed [TW-1:0] crcp;
        logic signed [TW-1:0] crsy;
        logic signed [TW-1:0] crcy;
        logic signed [TW-1:0] srsy;
        logic signed [TW-1:0] srcy;
    } triple_t;

    logic            p1_valid_reg;
    logic            p2_valid_reg;
    logic            p3_valid_reg;
    logic            p1_advance;
    logic            p2_advance;
    logic            p3_advance;
    pair_t           p1_reg;
    pair_t           p1_next;
    triple_t         p2_reg;
    triple_t         p2_next;
    ea2rm_pkg::mat_t p3_reg;
    ea2rm_pkg::mat_t p3_next;

    assign p3_advance = !p3_valid_reg || out_ready;
    assign p2_advance = !p2_valid_reg || p3_advance;
    assign p1_advance = !p1_valid_reg || p2_advance;
    assign in_ready = p1_advance;

    always_comb
    begin
        logic signed [TW-1:0] sr;
        logic signed [TW-1:0] cr;
        logic signed [TW-1:0] sp;
        logic signed [TW-1:0] cp;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
        sr = in_data.sn[0];
        cr = in_data.cs[0];
        sp = in_data.sn[1];
        cp = in_data.cs[1];
        sy = in_data.sn[2];
        cy = in_data.cs[2];
        p1_next.srsp = ea2rm_pkg::qmul(sr, sp);
        p1_next.crsp = ea2rm_pkg::qmul(cr, sp);
        p1_next.cpcy = ea2rm_pkg::qmul(cp, cy);
        p1_next.cpsy = ea2rm_pkg::qmul(cp, sy);
        p1_next.srcp = ea2rm_pkg::qmul(sr, cp);
        p1_next.crcp = ea2rm_pkg::qmul(cr, cp);
        p1_next.crsy = ea2rm_pkg::qmul(cr, sy);
        p1_next.crcy = ea2rm_pkg::qmul(cr, cy);
        p1_next.srsy = ea2rm_pkg::qmul(sr, sy);
        p1_next.srcy = ea2rm_pkg::qmul(sr, cy);
        p1_next.sy = sy;
        p1_next.cy = cy;
        p1_next.sp = sp;
    end

    always_comb
    begin
        p2_next.srspcy = ea2rm_pkg::qmul(p1_reg.srsp, p1_reg.cy);
        p2_next.srspsy = ea2rm_pkg::qmul(p1_reg.srsp, p1_reg.sy);
        p2_next.crspcy = ea2rm_pkg::qmul(p1_reg.crsp, p1_reg.cy);
        p2_next.crspsy = ea2rm_pkg::qmul(p1_reg.crsp, p1_reg.sy);
        p2_next.cpcy = p1_reg.cpcy;
        p2_next.cpsy = p1_reg.cpsy;
        p2_next.sp = p1_reg.sp;
        p2_next.srcp = p1_reg.srcp;
        p2_next.crcp = p1_reg.crcp;
        p2_next.crsy = p1_reg.crsy;
        p2_next.crcy = p1_reg.crcy;
        p2_next.srsy = p1_reg.srsy;
        p2_next.srcy = p1_reg.srcy;
    end

    function automatic logic signed [TW:0] ext(input logic signed [TW-1:0] v);
        return $signed({v[TW-1], v});
    endfunction

    always_comb
    begin
        p3_next.row0_col0 = ea2rm_pkg::to_q15(ext(p2_reg.cpcy));
        p3_next.row1_col0 = ea2rm_pkg::to_q15(ext(p2_reg.cpsy));
        p3_next.row2_col0 = ea2rm_pkg::to_q15(-ext(p2_reg.sp));
        p3_next.row0_col1 = ea2rm_pkg::to_q15(ext(p2_reg.srspcy) - ext(p2_reg.crsy));
        p3_next.row1_col1 = ea2rm_pkg::to_q15(ext(p2_reg.srspsy) + ext(p2_reg.crcy));
        p3_next.row2_col1 = ea2rm_pkg::to_q15(ext(p2_reg.srcp));
        p3_next.row0_col2 = ea2rm_pkg::to_q15(ext(p2_reg.crspcy) + ext(p2_reg.srsy));
        p3_next.row1_col2 = ea2rm_pkg::to_q15(ext(p2_reg.crspsy) - ext(p2_reg.srcy));
        p3_next.row2_col2 = ea2rm_pkg::to_q15(ext(p2_reg.crcp));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_advance)
                p1_valid_reg <= in_valid;
            if (p2_advance)
                p2_valid_reg <= p1_valid_reg;
            if (p3_advance)
                p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_advance && in_valid)
            p1_reg <= p1_next;
        if (p2_advance && p1_valid_reg)
            p2_reg <= p2_next;
        if (p3_advance && p2_valid_reg)
            p3_reg <= p3_next;
    end

    assign out_valid = p3_valid_reg;
    assign out_data = p3_reg;

    `EA_ASSERT(a_stall_holds, (p3_valid_reg && !out_ready)
        |=> (p3_valid_reg && $stable(p3_reg)), "stalled result changed or vanished")
    `EA_ASSERT_IMPL(a_no_overwrite, p2_valid_reg && !p2_advance,
        p3_valid_reg && !out_ready, "middle stage held without a downstream stall")

endmodule

FILE: design/euler_angles_to_rotation_matrix.sv
// ---------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// ZYX Euler angles (degrees, 7 fraction bits) to a Q1.15 3x3 rotation matrix.
// ---------------------------------------------------------------------------
// The block accepts one roll, pitch and yaw request in every cycle unless a
// stall has backed up to its input, and returns one matrix request per input,
// in order. The registered stages are angle wrapping and quadrant split, the
// CORDIC steps (the three angles run in parallel lanes), clamping and quadrant
// mapping, and the products, triple products and final sums with Q1.15
// rounding and saturation. Each stage stalls only when it holds data and the
// stage after it is not ready, so empty stages keep taking requests while a
// finished matrix waits on the output. No state is kept between requests.

module euler_angles_to_rotation_matrix #(
    parameter int CORDIC_STEPS = ea2rm_pkg::CORDIC_STEPS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    ea2rm_angle_if.sink   angles,
    ea2rm_matrix_if.source matrix
);

    logic                             red_valid;
    logic                             red_ready;
    ea2rm_pkg::red_t                  red_data;
    logic                             trig_valid;
    logic                             trig_ready;
    ea2rm_pkg::trig_t                 trig_data;
    ea2rm_pkg::mat_t                  mat_data;
    logic [2:0][ea2rm_pkg::ANG_W-1:0] angle_vec;

    assign angle_vec[0] = angles.roll_angle;
    assign angle_vec[1] = angles.pitch_angle;
    assign angle_vec[2] = angles.yaw_angle;

    ea2rm_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (angles.valid),
        .in_ready  (angles.ready),
        .in_angle  (angle_vec),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_data  (red_data)
    );

    ea2rm_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_data   (red_data),
        .out_valid (trig_valid),
        .out_ready (trig_ready),
        .out_data  (trig_data)
    );

    ea2rm_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .in_ready  (trig_ready),
        .in_data   (trig_data),
        .out_valid (matrix.valid),
        .out_ready (matrix.ready),
        .out_data  (mat_data)
    );

    assign matrix.row0_col0 = mat_data.row0_col0;
    assign matrix.row1_col0 = mat_data.row1_col0;
    assign matrix.row2_col0 = mat_data.row2_col0;
    assign matrix.row0_col1 = mat_data.row0_col1;
    assign matrix.row1_col1 = mat_data.row1_col1;
    assign matrix.row2_col1 = mat_data.row2_col1;
    assign matrix.row0_col2 = mat_data.row0_col2;
    assign matrix.row1_col2 = mat_data.row1_col2;
    assign matrix.row2_col2 = mat_data.row2_col2;

endmodule

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives roll, pitch and yaw requests into the rotation matrix block and
// compares every returned matrix with a fixed-point model of the CORDIC path.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int STEPS = ea2rm_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY = STEPS + 5;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint ONE30 = 64'sd1073741824;

    typedef struct {
        logic signed [ea2rm_pkg::ANG_W-1:0] roll;
        logic signed [ea2rm_pkg::ANG_W-1:0] pitch;
        logic signed [ea2rm_pkg::ANG_W-1:0] yaw;
    } angles_t;

    typedef enum int { PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH } phase_t;

    logic clk;
    logic rst_n;

    ea2rm_angle_if  angles ();
    ea2rm_matrix_if matrix ();

    euler_angles_to_rotation_matrix #(.CORDIC_STEPS(STEPS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles),
        .matrix (matrix)
    );

    angles_t           pending_angles[$];
    ea2rm_pkg::mat_t   expected_matrices[$];
    phase_t            phase;
    int                error_count;
    int                mismatch_count;
    int                matrices_checked;
    int                hold_off_cycles;
    bit                sender_paused;
    longint            cycle_count;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint shift_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    // Sine and cosine of one angle in Q1.30, mirroring the hardware CORDIC.
    function automatic void sin_cos(input logic signed [ea2rm_pkg::ANG_W-1:0] ang,
                                    output longint sn, output longint cs);
        longint a;
        longint q;
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint s0;
        longint c0;
        longint atan_tab[24];
        int n;
        atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115,
                     57, 29, 14, 7, 4, 2, 1, 0};
        a = longint'(ang) % 46080;
        if (a < 0)
            a += 46080;
        q = a / 11520;
        r = a - q * 11520;
        if (r == 0)
        begin
            s0 = 0;
            c0 = ONE30;
        end
        else
        begin
            n = (STEPS > 24) ? 24 : STEPS;
            x = 652032874;
            y = 0;
            z = r * 512;
            for (int i = 0; i < n; i++)
            begin
                dx = shift_floor(y, i);
                dy = shift_floor(x, i);
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_tab[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += atan_tab[i];
                end
            end
            s0 = (y < 0) ? 0 : ((y > ONE30) ? ONE30 : y);
            c0 = (x < 0) ? 0 : ((x > ONE30) ? ONE30 : x);
        end
        case (ea2rm_pkg::quad_t'(q[1:0]))
            ea2rm_pkg::QUAD_0: begin sn = s0;  cs = c0;  end
            ea2rm_pkg::QUAD_1: begin sn = c0;  cs = -s0; end
            ea2rm_pkg::QUAD_2: begin sn = -s0; cs = -c0; end
            default:           begin sn = -c0; cs = s0;  end
        endcase
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + (ONE30 >>> 1)) >>> 30;
    endfunction

    function automatic logic signed [ea2rm_pkg::OUT_W-1:0] round_q15(input longint v);
        longint t;
        t = (v + 16384) >>> 15;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t[ea2rm_pkg::OUT_W-1:0];
    endfunction

    function automatic ea2rm_pkg::mat_t rotation_matrix(input angles_t a);
        longint sr;
        longint cr;
        longint sp;
        longint cp;
        longint sy;
        longint cy;
        longint srsp;
        longint crsp;
        ea2rm_pkg::mat_t m;
        sin_cos(a.roll, sr, cr);
        sin_cos(a.pitch, sp, cp);
        sin_cos(a.yaw, sy, cy);
        srsp = mul_q30(sr, sp);
        crsp = mul_q30(cr, sp);
        m.row0_col0 = round_q15(mul_q30(cp, cy));
        m.row1_col0 = round_q15(mul_q30(cp, sy));
        m.row2_col0 = round_q15(-sp);
        m.row0_col1 = round_q15(mul_q30(srsp, cy) - mul_q30(cr, sy));
        m.row1_col1 = round_q15(mul_q30(srsp, sy) + mul_q30(cr, cy));
        m.row2_col1 = round_q15(mul_q30(sr, cp));
        m.row0_col2 = round_q15(mul_q30(crsp, cy) + mul_q30(sr, sy));
        m.row1_col2 = round_q15(mul_q30(crsp, sy) - mul_q30(sr, cy));
        m.row2_col2 = round_q15(mul_q30(cr, cp));
        return m;
    endfunction

    function automatic logic signed [ea2rm_pkg::ANG_W-1:0] any_angle();
        logic [ea2rm_pkg::ANG_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = ea2rm_pkg::ANG_W'($urandom);
            1:       v = ea2rm_pkg::ANG_W'($signed($urandom_range(0, 8)) * 11520 - 46080);
            // At or just beside a quarter turn.
            2:       v = ea2rm_pkg::ANG_W'($signed($urandom_range(0, 8)) * 11520 - 46080 +
                                           $signed($urandom_range(0, 2)) - 1);
            default: v = ea2rm_pkg::ANG_W'($signed($urandom_range(0, 92160)) - 46080);
        endcase
        return v;
    endfunction

    task automatic queue_angles(input int r, input int p, input int y);
        angles_t a;
        a.roll = ea2rm_pkg::ANG_W'(r);
        a.pitch = ea2rm_pkg::ANG_W'(p);
        a.yaw = ea2rm_pkg::ANG_W'(y);
        pending_angles.push_back(a);
    endtask

    // Sender: offers the head of the pending queue, idling at random by phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angles.valid <= 1'b0;
            angles.roll_angle <= '0;
            angles.pitch_angle <= '0;
            angles.yaw_angle <= '0;
        end
        else
        begin
            if (angles.valid && angles.ready)
            begin
                expected_matrices.push_back(rotation_matrix(pending_angles.pop_front()));
            end
            if ((angles.valid && !angles.ready) ||
                (pending_angles.size() > 0 && !sender_paused &&
                 !(angles.valid && angles.ready && pending_angles.size() == 0) &&
                 !((phase == PH_SRC_IDLE && $urandom_range(0, 99) < 71) ||
                   (phase == PH_BOTH && $urandom_range(0, 99) < 17))))
            begin
                if (!(angles.valid && !angles.ready) && pending_angles.size() > 0)
                begin
                    angles.valid <= 1'b1;
                    angles.roll_angle <= pending_angles[0].roll;
                    angles.pitch_angle <= pending_angles[0].pitch;
                    angles.yaw_angle <= pending_angles[0].yaw;
                end
            end
            else
            begin
                angles.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, or for a long stretch on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix.ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            matrix.ready <= 1'b0;
        end
        else
        begin
            matrix.ready <= !((phase == PH_SNK_STALL && $urandom_range(0, 99) < 71) ||
                              (phase == PH_BOTH && $urandom_range(0, 99) < 17));
        end
    end

    // Checker: compares each returned matrix with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && matrix.valid && matrix.ready)
        begin
            if (expected_matrices.size() == 0)
            begin
                error_count++;
                if (mismatch_count++ < 10)
                    $display("ERROR: matrix returned with none outstanding");
            end
            else
            begin
                ea2rm_pkg::mat_t e;
                ea2rm_pkg::mat_t got;
                e = expected_matrices.pop_front();
                got.row0_col0 = matrix.row0_col0;
                got.row1_col0 = matrix.row1_col0;
                got.row2_col0 = matrix.row2_col0;
                got.row0_col1 = matrix.row0_col1;
                got.row1_col1 = matrix.row1_col1;
                got.row2_col1 = matrix.row2_col1;
                got.row0_col2 = matrix.row0_col2;
                got.row1_col2 = matrix.row1_col2;
                got.row2_col2 = matrix.row2_col2;
                matrices_checked++;
                if (got !== e)
                begin
                    error_count++;
                    if (mismatch_count++ < 10)
                        $display("ERROR: matrix %0d expected %p got %p",
                                 matrices_checked, e, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic drain();
        while (pending_angles.size() > 0 || angles.valid || expected_matrices.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_batch(input int n);
        for (int i = 0; i < n; i++)
            queue_angles(any_angle(), any_angle(), any_angle());
    endtask

    initial
    begin
        error_count = 0;
        mismatch_count = 0;
        matrices_checked = 0;
        hold_off_cycles = 0;
        sender_paused = 1'b0;
        cycle_count = 0;
        phase = PH_FREE;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes, quarter turns, wrap past a full turn, tiny angles.
        queue_angles(0, 0, 0);
        queue_angles(46080, -46080, 46080);
        queue_angles(65535, -65536, 1);
        queue_angles(-1, 1, -1);
        queue_angles(11520, 0, 0);
        queue_angles(0, 11520, 0);
        queue_angles(0, 0, 11520);
        queue_angles(23040, 34560, -11520);
        queue_angles(-23040, -34560, 23040);
        queue_angles(0, -11520, 5760);
        queue_angles(5760, 5760, 5760);
        queue_angles(46081, -46081, 57600);
        queue_angles(11519, 11521, 34559);
        queue_angles(43 * 128, 17 * 128, 200 * 128);
        queue_angles(-65536, 65535, -65536);
        queue_angles(1, -1, 11519);
        drain();

        phase = PH_FREE;
        random_batch(150);
        drain();
        phase = PH_SRC_IDLE;
        random_batch(120);
        drain();
        phase = PH_SNK_STALL;
        random_batch(120);
        drain();

        // Long receiver hold-off while requests keep coming, to fill the pipe.
        phase = PH_FREE;
        @(posedge clk);
        hold_off_cycles <= 4 * LATENCY;
        random_batch(80);
        drain();

        // Sender pauses mid-stream until every matrix is back, then resumes.
        phase = PH_BOTH;
        random_batch(60);
        repeat (30) @(posedge clk);
        sender_paused = 1'b1;
        repeat (5) @(posedge clk);
        while (angles.valid || expected_matrices.size() > 0)
            @(posedge clk);
        sender_paused = 1'b0;
        random_batch(60);
        drain();

        repeat (LATENCY + 5) @(posedge clk);
        if (expected_matrices.size() > 0 || pending_angles.size() > 0)
            error_count++;
        $display("Checked %0d matrices over free, idle, stall and mixed phases,",
                 matrices_checked);
        $display("including quarter turns, wraps past 360 degrees and a full stall.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
